### src/itoa_pkg.sv
// Shared constants, types and helpers for the integer to ASCII digit converter.
// No dependencies; imported by every module of the block.
package itoa_pkg;

    localparam int MAX_CHARS = 16;
    // Characters per number never exceed the 16 hex digits of a 64-bit value.
    localparam int CHAR_LIM  = (MAX_CHARS < 16) ? MAX_CHARS : 16;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 5;
    localparam int NDIG_W  = 5;
    localparam int BIN_W   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W   = 4 * BCD_DIGITS;
    localparam int STEP_W  = $clog2(BIN_W);

    localparam logic [COUNT_W-1:0] CHAR_LIM_C = COUNT_W'(CHAR_LIM);

    localparam logic [1:0] OP_SDEC  = 2'd0;
    localparam logic [1:0] OP_UDEC  = 2'd1;
    localparam logic [1:0] OP_HEX32 = 2'd2;
    localparam logic [1:0] OP_HEX64 = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CONV
    } ctl_state_t;

    typedef enum logic [1:0] {
        FMT_IDLE,
        FMT_SKIP,
        FMT_SIGN,
        FMT_EMIT
    } fmt_state_t;

    // Digit word handed to the formatter: nibbles left-aligned, top nibble first.
    typedef struct packed {
        logic                 load;
        logic [VALUE_W-1:0]   digits;
        logic [NDIG_W-1:0]    ndig;
        logic                 neg;
    } fmt_load_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d,
                                                         input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < 4'd10) begin
            digit_to_ascii = ASCII_ZERO + CHAR_W'(d);
        end else begin
            digit_to_ascii = base + CHAR_W'(d - 4'd10);
        end
    endfunction

endpackage

### src/itoa_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on itoa_pkg.
module itoa_dabble import itoa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [BIN_W-1:0] bin,
    output logic             done,
    output logic [BCD_W-1:0] bcd
);

    logic [BIN_W-1:0]  bin_reg,  bin_next;
    logic [BCD_W-1:0]  bcd_reg,  bcd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = bin;
            bcd_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(BIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### src/itoa_fmt.sv
// Digit formatter: drops leading zeros a nibble per cycle, then emits the sign
// and digits as ASCII through the output register. Depends on itoa_pkg.
module itoa_fmt import itoa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fmt_load_t            req,
    input  logic                 upper,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic                 m_tlast
);

    fmt_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]  dig_reg,   dig_next;
    logic [NDIG_W-1:0]   ndig_reg,  ndig_next;
    logic                neg_reg,   neg_next;
    logic [COUNT_W-1:0]  sent_reg,  sent_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg,  char_next;
    logic                last_reg,  last_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_free;
    logic [COUNT_W-1:0]  sent_inc;
    logic                at_lim;

    assign out_free = !valid_reg || m_tready;
    assign sent_inc = sent_reg + 1'b1;
    assign at_lim   = (sent_inc == CHAR_LIM_C);

    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        ndig_next  = ndig_reg;
        neg_next   = neg_reg;
        sent_next  = sent_reg;
        valid_next = valid_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        count_next = count_reg;
        case (state_reg)
            FMT_IDLE: begin
                if (req.load) begin
                    dig_next   = req.digits;
                    ndig_next  = req.ndig;
                    neg_next   = req.neg;
                    sent_next  = '0;
                    state_next = FMT_SKIP;
                end
            end
            FMT_SKIP: begin
                if (ndig_reg > NDIG_W'(1) && dig_reg[VALUE_W-1 -: 4] == 4'd0) begin
                    dig_next  = {dig_reg[VALUE_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? FMT_SIGN : FMT_EMIT;
                end
            end
            FMT_SIGN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = at_lim;
                    count_next = at_lim ? sent_inc : '0;
                    sent_next  = sent_inc;
                    state_next = at_lim ? FMT_IDLE : FMT_EMIT;
                end
            end
            FMT_EMIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = digit_to_ascii(dig_reg[VALUE_W-1 -: 4], upper);
                    last_next  = at_lim || (ndig_reg == NDIG_W'(1));
                    count_next = last_next ? sent_inc : '0;
                    sent_next  = sent_inc;
                    dig_next   = {dig_reg[VALUE_W-5:0], 4'd0};
                    ndig_next  = ndig_reg - 1'b1;
                    if (last_next) begin
                        state_next = FMT_IDLE;
                    end
                end
            end
            default: begin
                state_next = FMT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FMT_IDLE;
            valid_reg <= 1'b0;
            sent_reg  <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
        dig_reg   <= dig_next;
        ndig_reg  <= ndig_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

    assign busy     = (state_reg != FMT_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, count_reg, char_reg};
    assign m_tlast  = last_reg;

endmodule

### src/integer_to_ascii_digits.sv
// Integer to ASCII digits: one request (value, opcode) in, its characters out
// most significant first, one per output beat. Depends on itoa_pkg, itoa_dabble
// and itoa_fmt.
//
// The time a request takes is set by two serial loops. Hex requests go
// straight to the formatter; decimal requests first pass the bit-serial BCD
// converter. The formatter then drops leading zeros one nibble per cycle and
// emits one character per cycle while the output is taken. Each dropped zero
// takes the place of one emitted character, so without output stalls the
// time to the last character does not depend on the digits of the value, only
// on the opcode and on a minus sign. A new request is taken at the edge after
// the last character of the previous one sits in the output register.
module integer_to_ascii_digits import itoa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_wdata,   // uppercase_hex
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,     // [63:0] value
    input  logic [1:0]         s_tuser,     // [1:0] opcode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,     // [6:0] digit_char, [11:7] char_count
    output logic               m_tlast      // last_char
);

    ctl_state_t        state_reg, state_next;
    logic              upper_reg;
    logic              neg_reg,   neg_next;
    logic              fmt_busy;
    logic              accept;
    logic              dab_start;
    logic              dab_done;
    logic [BCD_W-1:0]  dab_bcd;
    logic [BIN_W-1:0]  mag;
    logic              is_neg;
    fmt_load_t         fmt_req;

    assign s_tready = (state_reg == CTL_IDLE) && !fmt_busy;
    assign accept   = s_tvalid && s_tready;
    assign is_neg   = (s_tuser == OP_SDEC) && s_tdata[BIN_W-1];
    assign mag      = is_neg ? (~s_tdata[BIN_W-1:0] + 1'b1) : s_tdata[BIN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= 1'b0;
        end else if (cfg_we) begin
            upper_reg <= cfg_wdata;
        end
    end

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        dab_start      = 1'b0;
        fmt_req.load   = 1'b0;
        fmt_req.digits = {dab_bcd, {(VALUE_W-BCD_W){1'b0}}};
        fmt_req.ndig   = NDIG_W'(BCD_DIGITS);
        fmt_req.neg    = neg_reg;
        case (state_reg)
            CTL_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        OP_HEX32: begin
                            fmt_req.load   = 1'b1;
                            fmt_req.digits = {s_tdata[BIN_W-1:0], {(VALUE_W-BIN_W){1'b0}}};
                            fmt_req.ndig   = NDIG_W'(BIN_W / 4);
                            fmt_req.neg    = 1'b0;
                        end
                        OP_HEX64: begin
                            fmt_req.load   = 1'b1;
                            fmt_req.digits = s_tdata;
                            fmt_req.ndig   = NDIG_W'(VALUE_W / 4);
                            fmt_req.neg    = 1'b0;
                        end
                        default: begin
                            dab_start  = 1'b1;
                            neg_next   = is_neg;
                            state_next = CTL_CONV;
                        end
                    endcase
                end
            end
            CTL_CONV: begin
                if (dab_done) begin
                    fmt_req.load = 1'b1;
                    state_next   = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
        neg_reg <= neg_next;
    end

    itoa_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dab_start),
        .bin     (mag),
        .done    (dab_done),
        .bcd     (dab_bcd)
    );

    itoa_fmt u_fmt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (fmt_req),
        .upper    (upper_reg),
        .busy     (fmt_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
